/* rtl/kron_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kron_pkg
// shared constants, types and helpers of the binary kronecker symbol block
// ----------------------------------------------------------------------------
package kron_pkg;

    localparam int DATA_WIDTH = 64;

    typedef logic [DATA_WIDTH-1:0] t_data;

    // symbol encodings on the 2-bit signed result
    localparam logic [1:0] SYM_ZERO = 2'b00;
    localparam logic [1:0] SYM_POS  = 2'b01;
    localparam logic [1:0] SYM_NEG  = 2'b11;

    // status from the sequencer to the top level
    typedef struct packed {
        logic       idle;
        logic       done;
        logic [1:0] symbol;
    } t_status;

    // (2/n) is -1 for odd n of 3 or 5 mod 8
    function automatic logic two_neg(input logic [2:0] n);
        two_neg = (n inside {3'd3, 3'd5});
    endfunction

endpackage

/* rtl/kronecker_symbol_binary_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kronecker_symbol_binary_top
// kronecker symbol (a/b) of two signed words by the binary method
// ----------------------------------------------------------------------------
// usage
//   input channel: i_top_value (a) and i_bottom_value (b) with i_in_valid and
//   o_in_ready; a transaction takes place when both are high at a clock edge
//   output channel: o_symbol_value (+1, 0 or -1 as 2-bit two's complement)
//   with o_out_valid and i_out_ready; one result transaction per input
// sequencing
//   one item at a time; o_in_ready is high only while the sequencer is idle
//   a zero bottom or two even values go from the init state straight to done;
//   otherwise twos are stripped from the bottom one per cycle, then the
//   loop takes one shift or one subtract per cycle through the shared
//   subtract/compare unit; every shift halves a magnitude, a subtract never
//   grows ma*mb and at most one subtract comes per shift, so the strip and
//   the loop always end
// reset
//   synchronous, active low; sequencer returns to idle and the output
//   register empties; no state is carried between transactions
// stalls
//   the result sits in the output register until taken; the sequencer can
//   hand over its result as the old one leaves, else it waits in its done state
// ----------------------------------------------------------------------------
module kronecker_symbol_binary_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_top_value,
    input  logic [63:0] i_bottom_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_symbol_value
);
    import kron_pkg::*;

    t_status    w_status;
    logic       w_take;
    logic       w_start;
    logic       r_out_valid;
    logic [1:0] r_symbol;

    // output register can load when empty or being drained this cycle
    assign w_take  = !r_out_valid || i_out_ready;
    assign w_start = i_in_valid && o_in_ready;

    kron_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (i_top_value[DATA_WIDTH-1:0]),
        .i_b     (i_bottom_value[DATA_WIDTH-1:0]),
        .i_take  (w_take),
        .o_status(w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_status.done && w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_status.done && w_take) begin
            r_symbol <= w_status.symbol;
        end
    end

    assign o_in_ready     = w_status.idle;
    assign o_out_valid    = r_out_valid;
    assign o_symbol_value = r_symbol;

endmodule

/* rtl/kron_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kron_alu
// shared subtract and compare unit for the odd-value reduction loop
// ----------------------------------------------------------------------------
module kron_alu (
    input  kron_pkg::t_data i_ma,
    input  kron_pkg::t_data i_mb,
    output kron_pkg::t_data o_diff_ba,
    output kron_pkg::t_data o_diff_ab,
    output logic            o_b_gt_a
);
    import kron_pkg::*;

    logic [DATA_WIDTH:0] w_ba;

    assign w_ba      = {1'b0, i_mb} - {1'b0, i_ma};
    // borrow clear and nonzero difference means mb above ma
    assign o_b_gt_a  = !w_ba[DATA_WIDTH] && (w_ba[DATA_WIDTH-1:0] != '0);
    assign o_diff_ba = w_ba[DATA_WIDTH-1:0];
    assign o_diff_ab = i_ma - i_mb;

endmodule

/* rtl/kron_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kron_core
// sequencer and magnitude registers of the binary kronecker symbol loop
// ----------------------------------------------------------------------------
module kron_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  kron_pkg::t_data   i_a,
    input  kron_pkg::t_data   i_b,
    input  logic              i_take,
    output kron_pkg::t_status o_status
);
    import kron_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_STRIP = 3'd2;
    localparam logic [2:0] S_LOOP  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state, n_state;
    t_data      r_a, n_a, r_b, n_b;
    t_data      r_ma, n_ma, r_mb, n_mb;
    logic       r_par, n_par;
    logic       r_neg, n_neg;
    logic [1:0] r_sym, n_sym;

    t_data w_diff_ba, w_diff_ab;
    logic  w_b_gt_a;
    logic  w_a_neg, w_b_neg;

    kron_alu u_alu (
        .i_ma     (r_ma),
        .i_mb     (r_mb),
        .o_diff_ba(w_diff_ba),
        .o_diff_ab(w_diff_ab),
        .o_b_gt_a (w_b_gt_a)
    );

    assign w_a_neg = r_a[DATA_WIDTH-1];
    assign w_b_neg = r_b[DATA_WIDTH-1];

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_par   = r_par;
        n_neg   = r_neg;
        n_sym   = r_sym;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_a     = i_a;
                    n_b     = i_b;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                if (r_b == '0) begin
                    n_sym   = (r_a == t_data'(1) || r_a == '1) ? SYM_POS : SYM_ZERO;
                    n_state = S_DONE;
                end else if (!r_a[0] && !r_b[0]) begin
                    n_sym   = SYM_ZERO;
                    n_state = S_DONE;
                end else begin
                    n_ma    = w_a_neg ? (t_data'(0) - r_a) : r_a;
                    n_mb    = w_b_neg ? (t_data'(0) - r_b) : r_b;
                    n_par   = 1'b0;
                    n_state = S_STRIP;
                end
            end
            S_STRIP: begin
                // strip twos from the bottom magnitude, one per cycle
                if (!r_mb[0]) begin
                    n_mb  = r_mb >> 1;
                    n_par = !r_par;
                end else begin
                    n_neg   = (r_par & two_neg(r_a[2:0])) ^ (w_a_neg & w_b_neg)
                            ^ (w_a_neg & r_mb[1] & r_mb[0]);
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                if (r_ma == '0) begin
                    n_sym   = (r_mb[DATA_WIDTH-1:1] != '0) ? SYM_ZERO
                            : (r_neg ? SYM_NEG : SYM_POS);
                    n_state = S_DONE;
                end else if (!r_ma[0]) begin
                    // each stripped two multiplies by (2/mb)
                    n_ma  = r_ma >> 1;
                    n_neg = r_neg ^ two_neg(r_mb[2:0]);
                end else if (w_b_gt_a) begin
                    // swap with reciprocity flip when both are 3 mod 4
                    n_ma  = w_diff_ba;
                    n_mb  = r_ma;
                    n_neg = r_neg ^ (r_ma[1] & r_mb[1]);
                end else begin
                    n_ma = w_diff_ab;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_par <= n_par;
        r_neg <= n_neg;
        r_sym <= n_sym;
    end

    assign o_status.idle   = (r_state == S_IDLE);
    assign o_status.done   = (r_state == S_DONE);
    assign o_status.symbol = r_sym;

endmodule

/* rtl/kron_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kron_checker
// port-level checks of the kronecker symbol block, bound to the top level
// ----------------------------------------------------------------------------
module kron_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_symbol_value
);
    import kron_pkg::*;

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_symbol_value))
        else $error("result dropped or changed while stalled");

    // the pattern for -2 never appears
    a_sym_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_symbol_value != 2'b10))
        else $error("illegal symbol encoding");

    // one item at a time: busy right after an input transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while busy");

    // no result can appear in the cycle after an input transaction
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result appeared too early");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind kronecker_symbol_binary_top kron_checker u_kron_checker (.*);

/* verif/tb_kronecker_symbol_binary_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kronecker_symbol_binary_top
// self-checking bench for the binary kronecker symbol block
// ----------------------------------------------------------------------------
// each accepted operand pair is run through a behavioral model of the
// symbol, and the expected value is queued in a scoreboard; every result
// transaction is checked against the oldest entry. a directed set covers the
// corner operands, then random pairs mix full-width words, small values,
// words with long runs of trailing zeros and the extreme values. both sides
// idle in short random bursts, except near the end of the run.
// ----------------------------------------------------------------------------

class kron_scoreboard;

    logic [1:0]     expected_q[$];
    kron_pkg::t_data top_q[$];
    kron_pkg::t_data bottom_q[$];
    int errors;
    int noted;
    int count_pos;
    int count_zero;
    int count_neg;

    function new();
        errors     = 0;
        noted      = 0;
        count_pos  = 0;
        count_zero = 0;
        count_neg  = 0;
    endfunction

    // (2/n) for odd n, from n mod 8
    static function int two_sign(logic [2:0] n_low);
        case (n_low)
            3'd1, 3'd7: two_sign = 1;
            3'd3, 3'd5: two_sign = -1;
            default:    two_sign = 0;
        endcase
    endfunction

    static function logic [1:0] kronecker_of(kron_pkg::t_data a, kron_pkg::t_data b);
        kron_pkg::t_data mag_a;
        kron_pkg::t_data mag_b;
        kron_pkg::t_data diff;
        int              shifts;
        int              k;
        logic            a_neg;
        logic            b_neg;
        a_neg = a[kron_pkg::DATA_WIDTH-1];
        b_neg = b[kron_pkg::DATA_WIDTH-1];
        if (b == '0) begin
            return (a == kron_pkg::t_data'(1) || a == '1) ? kron_pkg::SYM_POS
                                                         : kron_pkg::SYM_ZERO;
        end
        if (!a[0] && !b[0]) begin
            return kron_pkg::SYM_ZERO;
        end
        // magnitudes fit unsigned, the most negative word included
        mag_b  = b_neg ? -b : b;
        shifts = 0;
        while (!mag_b[0]) begin
            mag_b = mag_b >> 1;
            shifts++;
        end
        k = shifts[0] ? two_sign(a[2:0]) : 1;
        if (a_neg && b_neg) begin
            k = -k;
        end
        mag_a = a_neg ? -a : a;
        if (a_neg && mag_b[1:0] == 2'b11) begin
            k = -k;
        end
        forever begin
            if (mag_a == '0) begin
                if (mag_b > kron_pkg::t_data'(1)) begin
                    k = 0;
                end
                break;
            end
            shifts = 0;
            while (!mag_a[0]) begin
                mag_a = mag_a >> 1;
                shifts++;
            end
            if (shifts[0]) begin
                k = two_sign(mag_b[2:0]) * k;
            end
            if (mag_b > mag_a) begin
                diff = mag_b - mag_a;
                // reciprocity: both 3 mod 4
                if (mag_a[1] && mag_b[1]) begin
                    k = -k;
                end
                mag_b = mag_a;
                mag_a = diff;
            end else begin
                mag_a = mag_a - mag_b;
            end
        end
        case (k)
            1:       return kron_pkg::SYM_POS;
            -1:      return kron_pkg::SYM_NEG;
            default: return kron_pkg::SYM_ZERO;
        endcase
    endfunction

    function void note_operands(kron_pkg::t_data a, kron_pkg::t_data b);
        logic [1:0] sym;
        sym = kronecker_of(a, b);
        expected_q.push_back(sym);
        top_q.push_back(a);
        bottom_q.push_back(b);
        noted++;
        if (sym == kron_pkg::SYM_POS) count_pos++;
        else if (sym == kron_pkg::SYM_NEG) count_neg++;
        else count_zero++;
    endfunction

    function void check_symbol(logic [1:0] actual);
        logic [1:0]      exp_sym;
        kron_pkg::t_data a;
        kron_pkg::t_data b;
        if (expected_q.size() == 0) begin
            $error("symbol_value: result with no transaction pending, actual %0d",
                   $signed(actual));
            errors++;
            return;
        end
        exp_sym = expected_q.pop_front();
        a       = top_q.pop_front();
        b       = bottom_q.pop_front();
        if (actual !== exp_sym) begin
            $error("symbol_value mismatch for a=%0d b=%0d: expected %0d actual %0d",
                   $signed(a), $signed(b), $signed(exp_sym), $signed(actual));
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void close_out();
        if (expected_q.size() != 0) begin
            $error("symbol_value: %0d expected results never arrived", expected_q.size());
            errors += expected_q.size();
        end
    endfunction

endclass

module tb_kronecker_symbol_binary_top;

    localparam int  RANDOM_PAIRS   = 400;
    localparam int  QUIET_AFTER    = 340;   // no idling from here on
    localparam int  DRAIN_CYCLES   = 300;   // beyond the worst-case latency
    localparam int  WATCHDOG_LIMIT = 3000;

    localparam kron_pkg::t_data MOST_NEG = {1'b1, {(kron_pkg::DATA_WIDTH-1){1'b0}}};
    localparam kron_pkg::t_data MOST_POS = {1'b0, {(kron_pkg::DATA_WIDTH-1){1'b1}}};
    localparam kron_pkg::t_data MINUS_ONE = '1;

    logic            i_clk          = 1'b0;
    logic            i_rst_n        = 1'b0;
    logic            i_in_valid     = 1'b0;
    logic            o_in_ready;
    kron_pkg::t_data i_top_value    = '0;
    kron_pkg::t_data i_bottom_value = '0;
    logic            o_out_valid;
    logic            i_out_ready    = 1'b1;
    logic [1:0]      o_symbol_value;

    kron_scoreboard  sb = new();
    logic            quiet = 1'b0;
    int              stall_left = 0;
    int              idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    kronecker_symbol_binary_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_top_value    (i_top_value),
        .i_bottom_value (i_bottom_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_symbol_value (o_symbol_value)
    );

    // result side: check each result transaction, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_symbol(o_symbol_value);
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(1, 5) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // called at a rising edge; returns at the edge that accepts the pair
    task automatic send_operands(kron_pkg::t_data a, kron_pkg::t_data b);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_top_value    <= a;
        i_bottom_value <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_operands(a, b);
    endtask

    function automatic kron_pkg::t_data random_operand();
        kron_pkg::t_data v;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = kron_pkg::t_data'(longint'($urandom_range(0, 128)) - 64);
            2: v = {32'h0, $urandom} | kron_pkg::t_data'(1);
            // long runs of trailing zeros
            3: v = ({$urandom, $urandom} >> $urandom_range(0, 63)) << $urandom_range(0, 40);
            4: begin
                case ($urandom_range(0, 6))
                    0: v = MOST_NEG;
                    1: v = MOST_POS;
                    2: v = '0;
                    3: v = kron_pkg::t_data'(1);
                    4: v = MINUS_ONE;
                    5: v = kron_pkg::t_data'(2);
                    default: v = MOST_NEG | kron_pkg::t_data'(1);
                endcase
            end
            default: v = kron_pkg::t_data'($urandom_range(0, 20'hfffff));
        endcase
        if ($urandom_range(0, 2) == 0) begin
            v = -v;
        end
        return v;
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero bottom: only a = +1 or -1 gives one
        send_operands('0, '0);
        send_operands(kron_pkg::t_data'(1), '0);
        send_operands(MINUS_ONE, '0);
        send_operands(kron_pkg::t_data'(2), '0);
        send_operands(MOST_NEG, '0);
        // both even
        send_operands(kron_pkg::t_data'(2), kron_pkg::t_data'(4));
        send_operands(MOST_NEG, MOST_NEG);
        // most negative bottom strips down to -1
        send_operands(kron_pkg::t_data'(3), MOST_NEG);
        send_operands(MOST_POS, MOST_NEG);
        send_operands(MINUS_ONE, MOST_NEG);
        // most negative top, exact magnitude
        send_operands(MOST_NEG, kron_pkg::t_data'(3));
        send_operands(MOST_NEG, -kron_pkg::t_data'(3));
        send_operands(MOST_NEG, MOST_POS);
        // sign handling and twos table
        send_operands(MOST_POS, MOST_POS);
        send_operands(MINUS_ONE, MINUS_ONE);
        send_operands(kron_pkg::t_data'(5), -kron_pkg::t_data'(7));
        send_operands(-kron_pkg::t_data'(5), -kron_pkg::t_data'(7));
        send_operands(kron_pkg::t_data'(2), kron_pkg::t_data'(7));
        send_operands(kron_pkg::t_data'(2), kron_pkg::t_data'(3));
        send_operands(MINUS_ONE, kron_pkg::t_data'(3));
        send_operands(MOST_POS, MINUS_ONE);
        send_operands(kron_pkg::t_data'(12345), kron_pkg::t_data'(8));
        send_operands(-kron_pkg::t_data'(3), -kron_pkg::t_data'(8));
        send_operands(kron_pkg::t_data'(7), {2'b01, {(kron_pkg::DATA_WIDTH-2){1'b0}}});
        send_operands('1, {$urandom, $urandom});

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n == QUIET_AFTER) begin
                quiet <= 1'b1;
            end
            send_operands(random_operand(), random_operand());
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.close_out();

        $display("ran %0d operand pairs through the symbol unit", sb.noted);
        $display("results seen: %0d of +1, %0d of 0, %0d of -1",
                 sb.count_pos, sb.count_zero, sb.count_neg);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
